// File: hdl/lrcc_pkg.sv
package lrcc_pkg;

   // ASCII codes the checker reacts to
   localparam logic [7:0] CHAR_C     = 8'h43;  // 'C'
   localparam logic [7:0] CHAR_L     = 8'h4C;  // 'L'
   localparam logic [7:0] CHAR_DOT   = 8'h2E;  // '.'
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
   localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
   localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   localparam int SUM_W   = 13;   // running sum mod 8192
   localparam int TOTAL_W = 14;   // sum plus the 'C' weight
   localparam int DOT_W   = 13;
   localparam int NUM_W   = 14;   // decimal value, at most 9999
   localparam int RCV_W   = 15;

   localparam logic [TOTAL_W-1:0] C_WEIGHT = TOTAL_W'(67);
   localparam logic [DOT_W-1:0]   DOT_MAX  = {DOT_W{1'b1}};
   localparam logic [1:0]         LAST_POS = 2'd3;

   // number reader stages
   localparam logic [1:0] STAGE_SKIP   = 2'd0;
   localparam logic [1:0] STAGE_DIGITS = 2'd1;
   localparam logic [1:0] STAGE_STOP   = 2'd2;

   typedef struct packed {
      logic [1:0]       stage;
      logic             negative;
      logic [NUM_W-1:0] value;
   } num_state_type;

   localparam num_state_type NUM_RESET = '{stage: STAGE_SKIP, negative: 1'b0,
                                           value: '0};

endpackage

// File: hdl/lrcc_atoi.sv
// One step of the decimal reader: next reader state for one byte.
module lrcc_atoi (
   input  logic [7:0]                  byte_value,
   input  lrcc_pkg::num_state_type     num_cur,
   output lrcc_pkg::num_state_type     num_next
);

   logic             is_white;
   logic             is_digit;
   logic [7:0]       digit_full;
   logic [3:0]       digit;
   logic [16:0]      scaled;

   assign is_white   = (byte_value == lrcc_pkg::CHAR_SPACE) ||
                       (byte_value >= lrcc_pkg::CHAR_TAB && byte_value <= lrcc_pkg::CHAR_CR);
   assign is_digit   = (byte_value >= lrcc_pkg::CHAR_ZERO) &&
                       (byte_value <= lrcc_pkg::CHAR_NINE);
   assign digit_full = byte_value - lrcc_pkg::CHAR_ZERO;
   assign digit      = digit_full[3:0];
   // value * 10 + digit; never exceeds 9999 within four bytes
   assign scaled     = ({3'b000, num_cur.value} << 3) + ({3'b000, num_cur.value} << 1)
                       + {13'd0, digit};

   always_comb begin
      num_next = num_cur;
      case (num_cur.stage)
         lrcc_pkg::STAGE_SKIP: begin
            if (is_white) begin
               num_next = num_cur;
            end else if (byte_value == lrcc_pkg::CHAR_PLUS ||
                         byte_value == lrcc_pkg::CHAR_MINUS) begin
               num_next.negative = (byte_value == lrcc_pkg::CHAR_MINUS);
               num_next.stage    = lrcc_pkg::STAGE_DIGITS;
            end else if (is_digit) begin
               num_next.value = {{(lrcc_pkg::NUM_W-4){1'b0}}, digit};
               num_next.stage = lrcc_pkg::STAGE_DIGITS;
            end else begin
               num_next.stage = lrcc_pkg::STAGE_STOP;
            end
         end
         lrcc_pkg::STAGE_DIGITS: begin
            if (is_digit) begin
               num_next.value = scaled[lrcc_pkg::NUM_W-1:0];
            end else begin
               num_next.stage = lrcc_pkg::STAGE_STOP;
            end
         end
         default: begin
            num_next = num_cur;   // stopped: later bytes ignored
         end
      endcase
   end

endmodule

// File: hdl/logger_response_checksum_check.sv
// Channel   Dir  Ports                                    Moves
// req       in   req_valid/req_ready, req_resp_byte       one response byte per item
// rsp       out  rsp_valid/rsp_ready, rsp_checksum_ok,    one check result per item
//                rsp_cell_count, rsp_computed_sum,
//                rsp_received_checksum
//
// One byte per cycle sustained, except while a held result stalls the input. A byte
// is captured in the input register, then updates the summing / number-reading
// state from that register; the fourth byte after 'C' loads the result register,
// so a result passes through the input and result registers. Synchronous reset
// clears all control state and both valid flags. A held result only stalls the
// byte that would produce the next result; other bytes keep flowing past it.
module logger_response_checksum_check (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_resp_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_checksum_ok,
   output logic [lrcc_pkg::DOT_W-1:0]          rsp_cell_count,
   output logic [lrcc_pkg::TOTAL_W-1:0]        rsp_computed_sum,
   output logic signed [lrcc_pkg::RCV_W-1:0]   rsp_received_checksum
);

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;

   // checker state
   logic                          phase_ff, phase_in;   // 1 = reading the number
   logic [lrcc_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic                          l_seen_ff, l_seen_in;
   logic [lrcc_pkg::DOT_W-1:0]    dot_ff, dot_in;
   logic [1:0]                    pos_ff, pos_in;
   lrcc_pkg::num_state_type       num_ff, num_in;
   lrcc_pkg::num_state_type       num_step;

   // result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                ok_ff, ok_in;
   logic [lrcc_pkg::DOT_W-1:0]          cell_ff, cell_in;
   logic [lrcc_pkg::TOTAL_W-1:0]        total_ff, total_in;
   logic signed [lrcc_pkg::RCV_W-1:0]   rcv_ff, rcv_in;

   logic                                out_free;
   logic                                makes_result;
   logic                                advance;
   logic                                load_rsp;
   logic signed [lrcc_pkg::RCV_W-1:0]   rcv_mag;

   lrcc_atoi u_atoi (
      .byte_value (in_byte_ff),
      .num_cur    (num_ff),
      .num_next   (num_step)
   );

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign makes_result = phase_ff && (pos_ff == lrcc_pkg::LAST_POS);
   assign advance      = in_valid_ff && (!makes_result || out_free);
   assign load_rsp     = advance && makes_result;
   assign req_ready    = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign in_byte_in   = (req_valid && req_ready) ? req_resp_byte : in_byte_ff;

   // result fields from the sum so far and the number after the last byte
   assign total_in = {1'b0, sum_ff} + lrcc_pkg::C_WEIGHT;
   assign rcv_mag  = $signed({1'b0, num_step.value});
   assign rcv_in   = num_step.negative ? -rcv_mag : rcv_mag;
   assign ok_in    = (rcv_in == $signed({1'b0, total_in}));
   assign cell_in  = dot_ff;

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || load_rsp;

   always_comb begin
      phase_in  = phase_ff;
      sum_in    = sum_ff;
      l_seen_in = l_seen_ff;
      dot_in    = dot_ff;
      pos_in    = pos_ff;
      num_in    = num_ff;
      if (advance) begin
         if (!phase_ff) begin
            if (in_byte_ff == lrcc_pkg::CHAR_C) begin
               // 'C' ends the body and is not summed
               phase_in = 1'b1;
               pos_in   = 2'd0;
               num_in   = lrcc_pkg::NUM_RESET;
            end else begin
               if (in_byte_ff == lrcc_pkg::CHAR_L) begin
                  l_seen_in = 1'b1;
               end
               if (!l_seen_ff && in_byte_ff == lrcc_pkg::CHAR_DOT &&
                   dot_ff != lrcc_pkg::DOT_MAX) begin
                  dot_in = dot_ff + 1'b1;
               end
               // wraps at 8192 by width
               sum_in = sum_ff + {{(lrcc_pkg::SUM_W-8){1'b0}}, in_byte_ff};
            end
         end else if (!makes_result) begin
            num_in = num_step;
            pos_in = pos_ff + 1'b1;
         end else begin
            // result goes out; start a new response
            phase_in  = 1'b0;
            sum_in    = '0;
            l_seen_in = 1'b0;
            dot_in    = '0;
            pos_in    = 2'd0;
            num_in    = lrcc_pkg::NUM_RESET;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         sum_ff       <= '0;
         l_seen_ff    <= 1'b0;
         dot_ff       <= '0;
         pos_ff       <= 2'd0;
         num_ff       <= lrcc_pkg::NUM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         sum_ff       <= sum_in;
         l_seen_ff    <= l_seen_in;
         dot_ff       <= dot_in;
         pos_ff       <= pos_in;
         num_ff       <= num_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      if (load_rsp) begin
         ok_ff    <= ok_in;
         cell_ff  <= cell_in;
         total_ff <= total_in;
         rcv_ff   <= rcv_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_checksum_ok       = ok_ff;
   assign rsp_cell_count        = cell_ff;
   assign rsp_computed_sum      = total_ff;
   assign rsp_received_checksum = rcv_ff;

endmodule

// File: hdl/lrcc_checker.sv
module lrcc_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                rsp_checksum_ok,
   input  logic [lrcc_pkg::DOT_W-1:0]          rsp_cell_count,
   input  logic [lrcc_pkg::TOTAL_W-1:0]        rsp_computed_sum,
   input  logic signed [lrcc_pkg::RCV_W-1:0]   rsp_received_checksum
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_computed_sum) &&
                                  $stable(rsp_received_checksum) &&
                                  $stable(rsp_cell_count))
      else $error("stalled result item changed");

   a_ok_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_checksum_ok ==
         ({1'b0, rsp_computed_sum} == $unsigned(rsp_received_checksum)))
      else $error("pass flag disagrees with the sums");

   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_computed_sum >= lrcc_pkg::C_WEIGHT &&
                    rsp_computed_sum <= lrcc_pkg::C_WEIGHT + lrcc_pkg::TOTAL_W'(8191))
      else $error("computed sum out of range");

   a_rcv_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_received_checksum >= -15'sd999 &&
                    rsp_received_checksum <= 15'sd9999)
      else $error("received checksum out of range");

endmodule

bind logger_response_checksum_check lrcc_checker u_lrcc_checker (.*);

// File: bench/checksum_result_checker.sv
`timescale 1ns / 1ps
module checksum_result_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [7:0]                          req_resp_byte,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                rsp_checksum_ok,
   input  logic [lrcc_pkg::DOT_W-1:0]          rsp_cell_count,
   input  logic [lrcc_pkg::TOTAL_W-1:0]        rsp_computed_sum,
   input  logic signed [lrcc_pkg::RCV_W-1:0]   rsp_received_checksum,
   output int                                  fail_count,
   output int                                  pending
);
   import lrcc_pkg::*;

   typedef enum logic {SUMMING, READING} phase_type;

   typedef struct packed {
      logic                    ok;
      logic [DOT_W-1:0]        cells;
      logic [TOTAL_W-1:0]      total;
      logic signed [RCV_W-1:0] received;
   } check_result_type;

   check_result_type expected_results[$];

   phase_type        phase;
   logic [SUM_W-1:0] body_sum;
   logic             l_seen;
   logic [DOT_W-1:0] dots;
   logic [1:0]       num_pos;
   logic [1:0]       num_stage;
   logic             num_neg;
   logic [NUM_W-1:0] num_value;

   task automatic clear_response();
      phase     = SUMMING;
      body_sum  = '0;
      l_seen    = 1'b0;
      dots      = '0;
      num_pos   = '0;
      num_stage = STAGE_SKIP;
      num_neg   = 1'b0;
      num_value = '0;
   endtask

   // advance the response state by one byte, queue a result after the fourth
   // byte following 'C'
   task automatic absorb_byte(input logic [7:0] b);
      check_result_type   r;
      logic [TOTAL_W-1:0] total;
      int                 value_signed;
      logic               is_digit;
      is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      if (phase == SUMMING) begin
         if (b == CHAR_C) begin
            phase     = READING;
            num_pos   = '0;
            num_stage = STAGE_SKIP;
            num_neg   = 1'b0;
            num_value = '0;
         end else begin
            if (b == CHAR_L)
               l_seen = 1'b1;
            if (!l_seen && b == CHAR_DOT && dots != DOT_MAX)
               dots = dots + 1'b1;
            body_sum = body_sum + b;   // wraps mod 8192
         end
      end else begin
         if (num_stage == STAGE_SKIP) begin
            if (b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR)) begin
               // leading white space
            end else if (b == CHAR_PLUS || b == CHAR_MINUS) begin
               num_neg   = (b == CHAR_MINUS);
               num_stage = STAGE_DIGITS;
            end else if (is_digit) begin
               num_value = NUM_W'(b - CHAR_ZERO);
               num_stage = STAGE_DIGITS;
            end else begin
               num_stage = STAGE_STOP;
            end
         end else if (num_stage == STAGE_DIGITS) begin
            if (is_digit)
               num_value = num_value * NUM_W'(10) + NUM_W'(b - CHAR_ZERO);
            else
               num_stage = STAGE_STOP;
         end
         if (num_pos != LAST_POS) begin
            num_pos = num_pos + 1'b1;
         end else begin
            total        = TOTAL_W'(body_sum) + C_WEIGHT;
            value_signed = num_neg ? -int'(num_value) : int'(num_value);
            r.ok         = (int'(total) == value_signed);
            r.cells      = dots;
            r.total      = total;
            r.received   = RCV_W'(value_signed);
            expected_results.push_back(r);
            clear_response();
         end
      end
   endtask

   always @(posedge clock) begin
      check_result_type e;
      if (reset) begin
         clear_response();
         expected_results.delete();
         fail_count = 0;
      end else begin
         if (req_valid && req_ready)
            absorb_byte(req_resp_byte);
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result with nothing expected (ok %0b cells %0d sum %0d rcv %0d)",
                        $time, rsp_checksum_ok, rsp_cell_count, rsp_computed_sum,
                        rsp_received_checksum);
               fail_count++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_checksum_ok !== e.ok) begin
                  $display("%0t: checksum_ok expected %0b got %0b",
                           $time, e.ok, rsp_checksum_ok);
                  fail_count++;
               end
               if (rsp_cell_count !== e.cells) begin
                  $display("%0t: cell_count expected %0d got %0d",
                           $time, e.cells, rsp_cell_count);
                  fail_count++;
               end
               if (rsp_computed_sum !== e.total) begin
                  $display("%0t: computed_sum expected %0d got %0d",
                           $time, e.total, rsp_computed_sum);
                  fail_count++;
               end
               if (rsp_received_checksum !== e.received) begin
                  $display("%0t: received_checksum expected %0d got %0d",
                           $time, e.received, rsp_received_checksum);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

// File: bench/tb_logger_response_checksum_check.sv
`timescale 1ns / 1ps
module tb_logger_response_checksum_check;
   import lrcc_pkg::*;

   localparam int SUM_TOP    = (1 << SUM_W) - 1;   // largest body sum
   localparam int LONG_HOLD  = 300;                // receiver back-pressure, cycles
   localparam int RAND_BYTES = 1250;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [7:0]                req_resp_byte;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic                      rsp_checksum_ok;
   logic [DOT_W-1:0]          rsp_cell_count;
   logic [TOTAL_W-1:0]        rsp_computed_sum;
   logic signed [RCV_W-1:0]   rsp_received_checksum;

   int fail_count;
   int pending;

   // bytes of the response being built, and the body sum the stimulus tracks
   // so it can append a matching checksum
   logic [7:0] msg[$];
   int         body_sum;
   int         bytes_sent;

   // per-response idling switches; cleared for stretches of full-rate traffic
   bit sender_idle;
   bit receiver_idle;
   bit hold_off_long;

   logger_response_checksum_check u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_resp_byte         (req_resp_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_checksum_ok       (rsp_checksum_ok),
      .rsp_cell_count        (rsp_cell_count),
      .rsp_computed_sum      (rsp_computed_sum),
      .rsp_received_checksum (rsp_received_checksum)
   );

   checksum_result_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_resp_byte         (req_resp_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_checksum_ok       (rsp_checksum_ok),
      .rsp_cell_count        (rsp_cell_count),
      .rsp_computed_sum      (rsp_computed_sum),
      .rsp_received_checksum (rsp_received_checksum),
      .fail_count            (fail_count),
      .pending               (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // hard stop
   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // one item on the request channel: optional gap, then hold valid until taken
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = sender_idle ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_resp_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic flush_msg();
      while (msg.size() != 0) send_byte(msg.pop_front());
   endtask

   task automatic push_body(input logic [7:0] b);
      msg.push_back(b);
      body_sum = (body_sum + b) % (SUM_TOP + 1);
   endtask

   function automatic logic [7:0] digit_char(input int v);
      return CHAR_ZERO + 8'(v % 10);
   endfunction

   // body byte: dots and 'L' often, otherwise anything but 'C'
   function automatic logic [7:0] body_char();
      logic [7:0] b;
      case ($urandom_range(0, 9))
         0, 1, 2: b = CHAR_DOT;
         3:       b = CHAR_L;
         4, 5, 6: b = 8'($urandom_range(0, 255));
         default: b = 8'($urandom_range(32, 126));
      endcase
      if (b == CHAR_C)
         b = CHAR_DOT;   // keep the body open
      return b;
   endfunction

   // a byte of a malformed number field
   function automatic logic [7:0] number_noise();
      case ($urandom_range(0, 7))
         0, 1:    return digit_char($urandom_range(0, 9));
         2:       return CHAR_SPACE;
         3:       return 8'($urandom_range(CHAR_TAB, CHAR_CR));
         4:       return CHAR_PLUS;
         5:       return CHAR_MINUS;
         6:       return CHAR_C;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // response: body, 'C', then a four-byte number field that is most
   // often the right checksum in one of the atoi-legal spellings
   task automatic build_response();
      int         len;
      int         total;
      int         pick;
      logic [7:0] ws;
      logic [7:0] lead;
      body_sum = 0;
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 150) : $urandom_range(0, 20);
      repeat (len) push_body(body_char());
      msg.push_back(CHAR_C);
      total = body_sum + int'(C_WEIGHT);
      ws = ($urandom_range(0, 1) == 0) ? CHAR_SPACE : 8'($urandom_range(CHAR_TAB, CHAR_CR));
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2, 3: begin
            for (int i = 3; i >= 0; i--) msg.push_back(digit_char(total / (10 ** i)));
         end
         4, 5: begin
            // short sums get a leading blank or '+' in the first slot
            lead = (total >= 1000) ? digit_char(total / 1000) :
                   (pick == 4) ? ws : CHAR_PLUS;
            msg.push_back(lead);
            for (int i = 2; i >= 0; i--) msg.push_back(digit_char(total / (10 ** i)));
         end
         6: begin
            msg.push_back(CHAR_MINUS);
            repeat (3) msg.push_back(digit_char($urandom_range(0, 9)));
         end
         default: begin
            repeat (4) msg.push_back(number_noise());
         end
      endcase
   endtask

   // result side: random stall before each item, one long hold-off on request
   initial begin
      int hold;
      rsp_ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         hold = receiver_idle ? $urandom_range(0, 14) : 0;
         if (hold_off_long) begin
            hold          = LONG_HOLD;
            hold_off_long = 1'b0;
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // stimulus and verdict
   initial begin
      int start;
      int resp;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_resp_byte = '0;
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      hold_off_long = 1'b0;
      bytes_sent    = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: byte extremes, dots before and after 'L', negative number
      msg = '{CHAR_DOT, CHAR_DOT, 8'h00, 8'hFF, CHAR_L, CHAR_DOT, CHAR_C,
              CHAR_MINUS, CHAR_NINE, CHAR_NINE, CHAR_NINE};
      flush_msg();
      // empty body, zero-padded matching checksum
      msg = '{CHAR_C, CHAR_ZERO, CHAR_ZERO, digit_char(6), digit_char(7)};
      flush_msg();
      // tab and CR skipped, then '+' and a digit
      msg = '{CHAR_C, CHAR_TAB, CHAR_CR, CHAR_PLUS, digit_char(4)};
      flush_msg();
      // high byte stops the number; 'C' and a digit after it are ignored
      msg = '{CHAR_C, CHAR_SPACE, 8'h80, CHAR_C, digit_char(7)};
      flush_msg();

      // a run of dots and the largest body sum, at full rate
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
      body_sum      = 0;
      repeat (40) push_body(CHAR_DOT);
      push_body(CHAR_L);
      while (SUM_TOP - body_sum >= 255) push_body(8'hFF);
      if (body_sum != SUM_TOP)
         push_body(8'(SUM_TOP - body_sum));
      msg.push_back(CHAR_C);
      for (int i = 3; i >= 0; i--)
         msg.push_back(digit_char((body_sum + int'(C_WEIGHT)) / (10 ** i)));
      flush_msg();

      // random responses; one burst at full rate against a long receiver stall
      start = bytes_sent;
      resp  = 0;
      while (bytes_sent - start < RAND_BYTES) begin
         sender_idle   = ($urandom_range(0, 3) != 0);
         receiver_idle = ($urandom_range(0, 3) != 0);
         if (resp == 20)
            hold_off_long = 1'b1;
         if (resp >= 20 && resp < 28)
            sender_idle = 1'b0;
         if ($urandom_range(0, 9) == 0) begin
            // noise: raw bytes, 'C' included, so responses get cut short
            repeat ($urandom_range(1, 10))
               msg.push_back(($urandom_range(0, 3) == 0) ? CHAR_C : 8'($urandom_range(0, 255)));
         end else begin
            build_response();
         end
         flush_msg();
         resp++;
      end
      req_valid <= 1'b0;

      // drain, then wait for anything unexpected to surface
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
